// File: sv/sle_pkg.sv
// Shared types and constants of the string literal unescaper.
package sle_pkg;

	// Slots per literal before the too-long error.
	localparam int MAX_LEN = 1024;
	localparam int SLOT_W  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;

	// Most results one character can cause.
	localparam int MAX_RES = 3;
	localparam int CNT_W   = 2;

	// Character codes.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_BELL   = 8'h07;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_CLOSED  = 2'd1,
		KIND_UNTERM  = 2'd2,
		KIND_TOOLONG = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_NUMBER = 3'b100
	} mode_t;

	typedef enum logic [1:0] {
		BASE_NONE = 2'd0,
		BASE_OCT  = 2'd1,
		BASE_DEC  = 2'd2,
		BASE_HEX  = 2'd3
	} base_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} result_t;

	// All results caused by one character, in delivery order.
	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		result_t [MAX_RES-1:0]     res;
	} res_set_t;

endpackage

// File: sv/sle_decoder.sv
// Input register, scan state and single-pass escape decode of one character.
module sle_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              at_end,
	input  logic              can_load,
	output logic              load,
	output sle_pkg::res_set_t res_set
);
	import sle_pkg::*;

	logic              s1_vld_q;
	logic [7:0]        ch_s1;
	logic              end_s1;

	mode_t             mode_q, mode_d;
	base_t             base_q, base_d;
	logic [7:0]        acc_q, acc_d;
	logic [SLOT_W-1:0] slot_q, slot_v;

	logic [CNT_W-1:0]  n_v;
	res_set_t          set_v;
	logic              f1_vld;
	logic [7:0]        f1_byte;
	logic              char_go;
	logic [4:0]        dig;
	logic [7:0]        acc_dec;

	// {ok, value} of c as a digit of base b.
	function automatic logic [4:0] digit_of(input logic [7:0] c, input base_t b);
		logic       is_dec;
		logic       is_let;
		logic [3:0] d;
		logic       ok;
		is_dec = (c >= 8'h30) && (c <= 8'h39);
		is_let = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
		d      = is_dec ? c[3:0] : (c[3:0] + 4'd9);
		case (b)
			BASE_OCT: ok = is_dec && !d[3];
			BASE_DEC: ok = is_dec;
			BASE_HEX: ok = is_dec || is_let;
			default:  ok = 1'b0;
		endcase
		return {ok, d};
	endfunction

	function automatic logic [7:0] letter_code(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h6E:     r = 8'd10;
			8'h74:     r = 8'd9;
			8'h66:     r = 8'd12;
			8'h72:     r = 8'd13;
			8'h76:     r = 8'd11;
			CH_BSLASH: r = CH_BELL;
			default:   r = c;
		endcase
		return r;
	endfunction

	assign load     = s1_vld_q && can_load;
	assign in_stall = s1_vld_q && !can_load;
	assign dig      = digit_of(ch_s1, base_q);
	assign acc_dec  = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + {4'd0, dig[3:0]};

	always_comb begin
		mode_d  = mode_q;
		base_d  = base_q;
		acc_d   = acc_q;
		slot_v  = slot_q;
		n_v     = '0;
		set_v   = '0;
		f1_vld  = 1'b0;
		f1_byte = acc_q;
		char_go = 1'b0;

		unique case (mode_q)
			MODE_ESCAPE: begin
				if (end_s1) begin
					mode_d  = MODE_NORMAL;
					char_go = 1'b1;
				end else if (ch_s1 == CH_X) begin
					mode_d = MODE_NUMBER;
					base_d = BASE_HEX;
					acc_d  = '0;
				end else if (ch_s1 == CH_ZERO) begin
					mode_d = MODE_NUMBER;
					base_d = BASE_OCT;
					acc_d  = '0;
				end else if (ch_s1 >= CH_ONE && ch_s1 <= CH_NINE) begin
					mode_d = MODE_NUMBER;
					base_d = BASE_DEC;
					acc_d  = {4'd0, ch_s1[3:0]};
				end else begin
					mode_d  = MODE_NORMAL;
					f1_vld  = 1'b1;
					f1_byte = letter_code(ch_s1);
				end
			end
			MODE_NUMBER: begin
				if (!end_s1 && dig[4]) begin
					case (base_q)
						BASE_HEX: acc_d = {acc_q[3:0], dig[3:0]};
						BASE_DEC: acc_d = acc_dec;
						default:  acc_d = {acc_q[4:0], dig[2:0]};
					endcase
				end else begin
					// flush the number, then treat this character as plain
					mode_d  = MODE_NORMAL;
					base_d  = BASE_NONE;
					acc_d   = '0;
					f1_vld  = 1'b1;
					f1_byte = acc_q;
					char_go = 1'b1;
				end
			end
			default: begin
				mode_d  = MODE_NORMAL;
				char_go = 1'b1;
			end
		endcase

		if (f1_vld) begin
			set_v.res[n_v].kind = KIND_DATA;
			set_v.res[n_v].data = f1_byte;
			n_v = n_v + 2'd1;
			if (slot_v == SLOT_W'(MAX_LEN - 1)) begin
				set_v.res[n_v].kind = KIND_TOOLONG;
				set_v.res[n_v].data = '0;
				n_v     = n_v + 2'd1;
				mode_d  = MODE_NORMAL;
				base_d  = BASE_NONE;
				acc_d   = '0;
				slot_v  = '0;
				char_go = 1'b0;
			end else begin
				slot_v = slot_v + SLOT_W'(1);
			end
		end

		if (char_go) begin
			if (end_s1 || ch_s1 == CH_QUOTE) begin
				set_v.res[n_v].kind = end_s1 ? KIND_UNTERM : KIND_CLOSED;
				set_v.res[n_v].data = '0;
				n_v    = n_v + 2'd1;
				mode_d = MODE_NORMAL;
				base_d = BASE_NONE;
				acc_d  = '0;
				slot_v = '0;
			end else if (ch_s1 == CH_BSLASH) begin
				mode_d = MODE_ESCAPE;
			end else begin
				set_v.res[n_v].kind = KIND_DATA;
				set_v.res[n_v].data = ch_s1;
				n_v = n_v + 2'd1;
				if (slot_v == SLOT_W'(MAX_LEN - 1)) begin
					set_v.res[n_v].kind = KIND_TOOLONG;
					set_v.res[n_v].data = '0;
					n_v    = n_v + 2'd1;
					mode_d = MODE_NORMAL;
					base_d = BASE_NONE;
					acc_d  = '0;
					slot_v = '0;
				end else begin
					slot_v = slot_v + SLOT_W'(1);
				end
			end
		end

		set_v.cnt = n_v;
	end

	assign res_set = set_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			mode_q   <= MODE_NORMAL;
			base_q   <= BASE_NONE;
			acc_q    <= '0;
			slot_q   <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				s1_vld_q <= 1'b1;
			end else if (load) begin
				s1_vld_q <= 1'b0;
			end
			if (load) begin
				mode_q <= mode_d;
				base_q <= base_d;
				acc_q  <= acc_d;
				slot_q <= slot_v;
			end
		end
	end

	// hold the character until its results are taken over
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1  <= ch;
			end_s1 <= at_end;
		end
	end

endmodule

// File: sv/sle_out_buf.sv
// Result register: holds the results of one character and hands them out a beat at a time.
module sle_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sle_pkg::res_set_t res_set,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [7:0]        data_byte,
	output logic              last
);
	import sle_pkg::*;

	logic [CNT_W-1:0]      cnt_q;
	result_t [MAX_RES-1:0] res_q;
	logic                  pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign can_load  = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !out_stall);
	assign kind      = res_q[0].kind;
	assign data_byte = res_q[0].data;
	assign last      = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res_set.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// advance the queue on each delivered beat
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_set.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

// File: sv/string_literal_unescaper_unit.sv
// Top level of the string literal unescaper: decoder plus result register.
//
// Feeds on the characters of a string literal that follow the opening quote, one
// character per input beat, and delivers decoded bytes on the output channel,
// then a "closed" beat at the closing quote. Escapes: backslash-x starts hex
// digits, backslash-0 octal digits, backslash-1..9 decimal digits including that
// first digit; a number ends at the first character that is not a digit of its
// base, which is then decoded as an ordinary character, and its value wraps to
// eight bits. Backslash n t f r v give the usual control codes, a doubled
// backslash gives code 7, any other escaped character stands for itself. An
// input beat with at_end set yields an unterminated error (after a pending number
// byte); MAX_LEN data bytes in one literal yield a too-long error right after the
// last byte. After "closed" or any error the next character starts a new
// literal. kind is 0 data, 1 closed, 2 unterminated, 3 too long; data_byte is
// zero for the non-data kinds, and last marks the final result beat of an input
// character. Rate: one input beat per cycle as long as each character yields at
// most one result and out_stall is low; a character that yields two or three
// results holds the input while the single output register drains one beat per
// cycle while out_stall is low. The first result of an input beat passes the
// input register, then the result register.
module string_literal_unescaper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       at_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic       last
);
	import sle_pkg::*;

	logic     can_load;
	logic     load;
	res_set_t res_set;

	// Decode one held character against the scan state.
	sle_decoder u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.at_end   (at_end),
		.can_load (can_load),
		.load     (load),
		.res_set  (res_set)
	);

	// Hold the result set and drain it one beat per cycle while out_stall is low.
	sle_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_set   (res_set),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.last      (last)
	);

	// Non-data results carry a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_DATA) |-> (data_byte == 8'd0))
		else $error("non-data result carries a byte");

	// Closed and error results always end the set of their character.
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_DATA) |-> last)
		else $error("terminating result not marked last");

	// A refused load means a result is still waiting.
	a_refuse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!can_load |-> (out_valid && (out_stall || !last)))
		else $error("result register refused a load while free");

	// A result that is not last is followed by another one.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("result set cut short");

endmodule

// File: dv/tb.sv
// Testbench for string_literal_unescaper_unit: self-checking decode of escaped string literals.
module tb;
	import sle_pkg::*;

	// Control codes that the letter escapes stand for.
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_VT  = 8'h0B;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_CR  = 8'h0D;

	// Random part: character beats to queue after the directed and limit phases.
	localparam int RANDOM_BEATS = 150;
	// Receiver hold-off: start once this many beats went in, last this many cycles.
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 64;
	// Window of cycles with no random idling on either side.
	localparam int QUIET_FROM   = 300;
	localparam int QUIET_TO     = 1300;
	localparam int MAX_PRINTS   = 40;

	// One input beat as queued for the driver; hold asks the driver to wait for
	// every expected result before offering it.
	typedef struct packed {
		logic [7:0] c;
		logic       e;
		logic       hold;
	} char_beat_t;

	// One result beat as predicted.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_beat_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] ch        = '0;
	logic       at_end    = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       last;

	char_beat_t   char_q[$];       // beats still to be offered
	result_beat_t decoded_q[$];    // decoded results still to arrive
	result_beat_t step_beats[$];   // results of the character being decoded

	// Mirror of the decoder state.
	mode_t      lit_mode  = MODE_NORMAL;
	base_t      lit_base  = BASE_NONE;
	logic [7:0] lit_acc   = '0;
	int         lit_slots = 0;

	logic pause_next = 1'b0;
	logic in_took    = 1'b0;
	int   cyc        = 0;
	int   beats_in   = 0;
	int   errors     = 0;
	int   hold_left  = 0;
	bit   hold_done  = 1'b0;
	int   n_data, n_closed, n_unterm, n_toolong;

	string hex_digits = "0123456789abcdefABCDEF";
	string oct_digits = "01234567";
	string dec_digits = "0123456789";
	string esc_chars  = "ntfrv\\qA\"";

	wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	string_literal_unescaper_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.at_end    (at_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_beat(kind_t k, logic [7:0] d);
		step_beats.push_back('{kind: k, data: d, last: 1'b0});
	endfunction

	// Back to the start of a literal: after closed, after any error.
	function automatic void clear_literal();
		lit_mode  = MODE_NORMAL;
		lit_base  = BASE_NONE;
		lit_acc   = '0;
		lit_slots = 0;
	endfunction

	// Emit one data byte into a slot; return 1 if that filled the last slot.
	function automatic bit add_byte(logic [7:0] d);
		add_beat(KIND_DATA, d);
		lit_slots++;
		if (lit_slots >= MAX_LEN) begin
			add_beat(KIND_TOOLONG, 8'h00);
			clear_literal();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] escape_code(logic [7:0] c);
		case (c)
			"n":       return CODE_LF;
			"t":       return CODE_TAB;
			"f":       return CODE_FF;
			"r":       return CODE_CR;
			"v":       return CODE_VT;
			CH_BSLASH: return CH_BELL;
			default:   return c;
		endcase
	endfunction

	// Digit value of c in base b, or -1 where c is no digit of it.
	function automatic int digit_in_base(logic [7:0] c, base_t b);
		int d;
		d = -1;
		if (c >= "0" && c <= "9")
			d = c - "0";
		else if (c >= "a" && c <= "f")
			d = c - "a" + 10;
		else if (c >= "A" && c <= "F")
			d = c - "A" + 10;
		case (b)
			BASE_OCT: return (d >= 0 && d < 8) ? d : -1;
			BASE_DEC: return (d >= 0 && d < 10) ? d : -1;
			BASE_HEX: return d;
			default:  return -1;
		endcase
	endfunction

	function automatic void plain_char(logic [7:0] c, logic e);
		if (e) begin
			add_beat(KIND_UNTERM, 8'h00);
			clear_literal();
		end else if (c == CH_QUOTE) begin
			add_beat(KIND_CLOSED, 8'h00);
			clear_literal();
		end else if (c == CH_BSLASH) begin
			lit_mode = MODE_ESCAPE;
		end else begin
			void'(add_byte(c));
		end
	endfunction

	// Decode one accepted character beat and queue the results it causes.
	function automatic void decode_char(logic [7:0] c, logic e);
		int         d;
		int         radix;
		logic [7:0] v;
		step_beats.delete();
		case (lit_mode)
			MODE_ESCAPE: begin
				if (e) begin
					add_beat(KIND_UNTERM, 8'h00);
					clear_literal();
				end else if (c == CH_X) begin
					lit_mode = MODE_NUMBER;
					lit_base = BASE_HEX;
					lit_acc  = '0;
				end else if (c == CH_ZERO) begin
					lit_mode = MODE_NUMBER;
					lit_base = BASE_OCT;
					lit_acc  = '0;
				end else if (c >= CH_ONE && c <= CH_NINE) begin
					lit_mode = MODE_NUMBER;
					lit_base = BASE_DEC;
					lit_acc  = c - CH_ZERO;
				end else begin
					lit_mode = MODE_NORMAL;
					void'(add_byte(escape_code(c)));
				end
			end
			MODE_NUMBER: begin
				d = e ? -1 : digit_in_base(c, lit_base);
				if (d >= 0) begin
					radix   = (lit_base == BASE_HEX) ? 16 : (lit_base == BASE_DEC) ? 10 : 8;
					lit_acc = 8'(int'(lit_acc) * radix + d);
				end else begin
					// The number ends here; the terminator is decoded as a plain
					// character unless the number byte hit the length limit.
					v        = lit_acc;
					lit_mode = MODE_NORMAL;
					lit_base = BASE_NONE;
					lit_acc  = '0;
					if (!add_byte(v))
						plain_char(c, e);
				end
			end
			default: begin
				lit_mode = MODE_NORMAL;
				plain_char(c, e);
			end
		endcase
		if (step_beats.size() > 0)
			step_beats[step_beats.size() - 1].last = 1'b1;
		foreach (step_beats[i])
			decoded_q.push_back(step_beats[i]);
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void push_item(logic [7:0] c, logic e);
		char_q.push_back('{c: c, e: e, hold: pause_next});
		pause_next = 1'b0;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], 1'b0);
	endfunction

	// Any byte that is neither a quote nor a backslash.
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic void fill_slots(int n);
		repeat (n) push_item(plain_byte(), 1'b0);
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Well-formed literal with random content: plain bytes, letter escapes and
	// number escapes of each base, closed by a quote or cut by end of input.
	function automatic void queue_literal();
		int r;
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				push_item(plain_byte(), 1'b0);
			end else if (r < 6) begin
				push_item(CH_BSLASH, 1'b0);
				push_item(pick(esc_chars), 1'b0);
			end else if (r == 6) begin
				push_item(CH_BSLASH, 1'b0);
				push_item(CH_X, 1'b0);
				repeat ($urandom_range(0, 3)) push_item(pick(hex_digits), 1'b0);
			end else if (r == 7) begin
				push_item(CH_BSLASH, 1'b0);
				push_item(CH_ZERO, 1'b0);
				repeat ($urandom_range(0, 3)) push_item(pick(oct_digits), 1'b0);
			end else if (r == 8) begin
				push_item(CH_BSLASH, 1'b0);
				push_item(8'(CH_ONE + $urandom_range(0, 8)), 1'b0);
				repeat ($urandom_range(0, 2)) push_item(pick(dec_digits), 1'b0);
			end else begin
				// Escape of an arbitrary byte, digits and x included.
				push_item(CH_BSLASH, 1'b0);
				push_item(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		if ($urandom_range(0, 9) < 8)
			push_item(CH_QUOTE, 1'b0);
		else
			push_item(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// Noise: arbitrary bytes, now and then an end of input.
	function automatic void queue_noise();
		repeat ($urandom_range(1, 6))
			push_item(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Sample both handshakes at the rising edge: compare the result beat with the
	// oldest prediction, then predict for the character beat that went in.
	always @(posedge clk) begin : check_results
		result_beat_t want;
		cyc     <= cyc + 1;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (decoded_q.size() == 0) begin
					note_mismatch($sformatf("result beat kind %0d data %02h with nothing expected",
						kind, data_byte));
				end else begin
					want = decoded_q.pop_front();
					if (kind !== want.kind)
						note_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
					if (data_byte !== want.data)
						note_mismatch($sformatf("data_byte %02h, expected %02h",
							data_byte, want.data));
					if (last !== want.last)
						note_mismatch($sformatf("last %0b, expected %0b", last, want.last));
					case (want.kind)
						KIND_DATA:   n_data++;
						KIND_CLOSED: n_closed++;
						KIND_UNTERM: n_unterm++;
						default:     n_toolong++;
					endcase
				end
			end
			if (in_valid && !in_stall) begin
				decode_char(ch, at_end);
				beats_in++;
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// Sender: hold a stalled beat, otherwise advance to the next queued one unless
	// idling or told to wait for the pipeline to drain.
	always @(negedge clk) begin : drive_chars
		char_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold the beat until it is taken
		end else if (char_q.size() == 0 || (!quiet && $urandom_range(0, 99) < 7) ||
				(char_q[0].hold && decoded_q.size() != 0)) begin
			in_valid <= 1'b0;
		end else begin
			nxt = char_q.pop_front();
			in_valid <= 1'b1;
			ch       <= nxt.c;
			at_end   <= nxt.e;
		end
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps
	// offering, so that the block backs up into its input.
	always @(negedge clk) begin : stall_results
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!hold_done && beats_in >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 7);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run
		int start;
		n_data    = 0;
		n_closed  = 0;
		n_unterm  = 0;
		n_toolong = 0;

		// Directed: extreme bytes, letter escapes, the doubled backslash, a hex
		// number that wraps and ends at the quote, a decimal number that wraps
		// and ends at a letter, end of input inside a number, inside an escape
		// and in plain text.
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_text("\\n\\\\");
		push_text("\\x1ff\"");
		push_text("\\300A");
		push_text("\\0777");
		push_item(8'hFF, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(8'h00, 1'b1);
		push_item(CH_QUOTE, 1'b1);

		// Length limit: a plain byte filling the last slot; a number byte and its
		// plain terminator with the terminator filling the last slot (three
		// results); a number byte filling the last slot with the quote after it
		// dropped.
		pause_next = 1'b1;
		fill_slots(MAX_LEN - 1);
		push_item(plain_byte(), 1'b0);
		fill_slots(MAX_LEN - 2);
		push_text("\\x41G");
		fill_slots(MAX_LEN - 1);
		push_text("\\7\"");

		// Random literals and noise, after the pipeline drains once more.
		pause_next = 1'b1;
		start = char_q.size();
		while (char_q.size() - start < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) < 8)
				queue_literal();
			else
				queue_noise();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last beat to go in and every result to come out, then watch
		// for stray beats. The input side is looked at on the rising edge, where the
		// driven beat is settled.
		while (char_q.size() != 0 || in_valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);

		$display("Fed %0d character beats: directed escapes and number wraps, three limit",
			beats_in);
		$display("cases and random literals; results %0d data, %0d closed, %0d unterm, %0d too long",
			n_data, n_closed, n_unterm, n_toolong);
		if (errors == 0)
			$display("[string_literal_unescaper_unit] OK");
		else
			$display("[string_literal_unescaper_unit] ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("timeout with %0d beats queued and %0d results outstanding",
			char_q.size(), decoded_q.size());
		$display("[string_literal_unescaper_unit] ERROR");
		$finish;
	end

endmodule
